// ===== rtl/core/dchc_pkg.sv =====
// dchc_pkg: shared types and constants of the direct-mapped cache hit counter.
// No dependencies; imported by the controller, the datapath and the top level.
package dchc_pkg;

	localparam int KIND_W = 2;
	localparam int ADDR_W = 32;
	localparam int CNT_W  = 32;

	localparam logic [KIND_W-1:0] KIND_ACCESS = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INVAL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ZERO   = 2'd2;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_LOOKUP,
		ST_WIPE,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic finish;
		logic clr_step;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic clr_last;
	} dp_stat_t;

endpackage

// ===== rtl/core/dchc_ram.sv =====
// dchc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module dchc_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/dchc_ctrl.sv =====
// dchc_ctrl: sequencer for lookups, invalidate sweeps and counter items.
// Depends on dchc_pkg for the state, command and status types.
module dchc_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [dchc_pkg::KIND_W-1:0]   kind,
	input  dchc_pkg::dp_stat_t            stat,
	output dchc_pkg::dp_cmd_t             cmd,
	output logic                          in_stall
);

	import dchc_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.finish   = 1'b0;
		cmd.clr_step = 1'b0;
		in_stall     = 1'b1;
		case (state_q)
			ST_INIT: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (kind)
						KIND_ACCESS: state_d = ST_LOOKUP;
						KIND_INVAL:  state_d = ST_WIPE;
						default:     state_d = ST_DONE;
					endcase
				end
			end
			ST_LOOKUP, ST_DONE: begin
				if (stat.slot_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_WIPE: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_DONE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

endmodule

// ===== rtl/core/dchc_dp.sv =====
// dchc_dp: address split, tag RAM, hit compare, counters and result register.
// Depends on dchc_pkg and dchc_ram.
module dchc_dp #(
	parameter int NUM_LINES  = 32,
	parameter int LINE_BITS  = 1024,
	parameter int ADDR_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dchc_pkg::dp_cmd_t             cmd,
	output dchc_pkg::dp_stat_t            stat,
	input  logic [dchc_pkg::KIND_W-1:0]   kind,
	input  logic [dchc_pkg::ADDR_W-1:0]   addr,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [dchc_pkg::CNT_W-1:0]    hit_count,
	output logic [dchc_pkg::CNT_W-1:0]    miss_count
);

	import dchc_pkg::*;

	localparam int IDX_W   = $clog2(NUM_LINES);
	localparam int OFF_W   = $clog2(LINE_BITS);
	localparam int EFF_W   = (ADDR_WIDTH < ADDR_W) ? ADDR_WIDTH : ADDR_W;
	localparam int TAG_RAW = EFF_W - OFF_W - IDX_W;
	localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
	localparam int SH_TAG  = OFF_W + IDX_W;
	localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - EFF_W);
	localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(NUM_LINES - 1);

	logic [ADDR_W-1:0] addr_m;
	logic [ADDR_W-1:0] blk;
	logic [ADDR_W-1:0] tag_full;
	logic [IDX_W-1:0]  idx_in;
	logic [TAG_W-1:0]  tag_in;

	logic [KIND_W-1:0] kind_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TAG_W-1:0]  tag_q;
	logic [IDX_W-1:0]  clr_idx_q;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [TAG_W:0]    ram_wdata;
	logic [TAG_W:0]    ram_rdata;

	logic              hit_now;
	logic              is_access;
	logic              out_valid_q;
	logic              hit_q;
	logic [CNT_W-1:0]  hits_q;
	logic [CNT_W-1:0]  misses_q;

	assign addr_m   = addr & ADDR_MASK;
	assign blk      = addr_m >> OFF_W;
	assign tag_full = addr_m >> SH_TAG;
	assign idx_in   = blk[IDX_W-1:0];
	assign tag_in   = tag_full[TAG_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= kind;
			idx_q  <= idx_in;
			tag_q  <= tag_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_step) begin
			clr_idx_q <= (clr_idx_q == IDX_LAST) ? '0 : clr_idx_q + 1'b1;
		end
	end

	assign is_access = (kind_q == KIND_ACCESS);
	assign hit_now   = is_access && ram_rdata[TAG_W] && (ram_rdata[TAG_W-1:0] == tag_q);

	assign ram_we    = cmd.clr_step || (cmd.finish && is_access && !hit_now);
	assign ram_waddr = cmd.clr_step ? clr_idx_q : idx_q;
	assign ram_wdata = cmd.clr_step ? '0 : {1'b1, tag_q};

	dchc_ram #(
		.WIDTH (TAG_W + 1),
		.DEPTH (NUM_LINES)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.accept),
		.raddr (idx_in),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q      <= '0;
			misses_q    <= '0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
			hit_q       <= hit_now;
			case (kind_q)
				KIND_ACCESS: begin
					if (hit_now) begin
						hits_q <= hits_q + 1'b1;
					end else begin
						misses_q <= misses_q + 1'b1;
					end
				end
				KIND_ZERO: begin
					hits_q   <= '0;
					misses_q <= '0;
				end
				default: begin
					hits_q <= hits_q;
				end
			endcase
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.slot_free = !out_valid_q || !out_stall;
	assign stat.clr_last  = (clr_idx_q == IDX_LAST);

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign hit_count  = hits_q;
	assign miss_count = misses_q;

endmodule

// ===== rtl/core/direct_mapped_cache_hit_counter_unit.sv =====
// direct_mapped_cache_hit_counter_unit: top level of the cache hit counter.
// Depends on dchc_pkg, dchc_ctrl, dchc_dp (and dchc_ram below it).
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------
//   in      | in_valid  | in_stall  | kind, addr
//   out     | out_valid | out_stall | hit, hit_count, miss_count
//
// An access or counter item is accepted with a tag RAM read, then the
// compare, update and result load follow. Invalidate runs the
// one-line-per-cycle sweep over the tag RAM write port before its result.
// After reset the same sweep runs over all NUM_LINES lines with in_stall high.
// One result is held in the output register, so an item is accepted while it
// waits; the next item's finish holds until out_stall drops.
module direct_mapped_cache_hit_counter_unit #(
	parameter int NUM_LINES  = 32,
	parameter int LINE_BITS  = 1024,
	parameter int ADDR_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dchc_pkg::KIND_W-1:0]   kind,
	input  logic [dchc_pkg::ADDR_W-1:0]   addr,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [dchc_pkg::CNT_W-1:0]    hit_count,
	output logic [dchc_pkg::CNT_W-1:0]    miss_count
);

	import dchc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	dchc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.stat     (stat),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	dchc_dp #(
		.NUM_LINES  (NUM_LINES),
		.LINE_BITS  (LINE_BITS),
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.kind       (kind),
		.addr       (addr),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.hit_count  (hit_count),
		.miss_count (miss_count)
	);

endmodule

// ===== tb/sv/tb_direct_mapped_cache_hit_counter_unit.sv =====
// tb_direct_mapped_cache_hit_counter_unit: self-checking bench for the cache hit counter.
// Runs a directed table, then random mixed-kind traces against a tag store predictor.
// Depends on dchc_pkg and direct_mapped_cache_hit_counter_unit.
module tb_direct_mapped_cache_hit_counter_unit;
	import dchc_pkg::*;

	localparam int NUM_LINES    = 32;
	localparam int LINE_BITS    = 1024;
	localparam int OFS_W        = $clog2(LINE_BITS);
	localparam int IDX_W        = $clog2(NUM_LINES);
	localparam int TAG_W        = ADDR_W - OFS_W - IDX_W;
	localparam int RESET_CYCLES = 12;
	localparam int RAND_ITEMS   = 1630;
	localparam int PHASE_LEN    = 200;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = NUM_LINES + 8;
	localparam int CYCLE_LIMIT  = 500000;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic             hit;
		logic [CNT_W-1:0] hit_count;
		logic [CNT_W-1:0] miss_count;
	} result_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] addr;
		logic              typed;
		result_t           res;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [KIND_W-1:0] kind;
	logic [ADDR_W-1:0] addr;
	logic              out_valid;
	logic              out_stall;
	logic              hit;
	logic [CNT_W-1:0]  hit_count;
	logic [CNT_W-1:0]  miss_count;

	logic    row_typed;
	result_t row_res;

	logic [NUM_LINES-1:0] line_ok;
	logic [TAG_W-1:0]     line_tag_q [NUM_LINES];
	logic [CNT_W-1:0]     hits_q;
	logic [CNT_W-1:0]     misses_q;

	result_t   predicted_results [$];
	stim_row_t dir_rows [$];

	int  errors;
	int  results_seen;
	int  cycle_cnt;
	int  n_access, n_hits, n_inval, n_zero, n_unused, n_held_off;
	bit  no_idle;
	bit  hold_req;

	direct_mapped_cache_hit_counter_unit #(
		.NUM_LINES (NUM_LINES),
		.LINE_BITS (LINE_BITS),
		.ADDR_WIDTH(ADDR_W)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.addr      (addr),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.hit_count (hit_count),
		.miss_count(miss_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic result_t lookup_and_count(input logic [KIND_W-1:0] k,
		input logic [ADDR_W-1:0] a);
		result_t          r;
		logic [IDX_W-1:0] idx;
		logic [TAG_W-1:0] tg;
		idx   = a[OFS_W +: IDX_W];
		tg    = a[ADDR_W-1 -: TAG_W];
		r.hit = 1'b0;
		case (k)
			KIND_ACCESS: begin
				if (line_ok[idx] && line_tag_q[idx] == tg) begin
					r.hit  = 1'b1;
					hits_q = hits_q + 1'b1;
				end else begin
					misses_q        = misses_q + 1'b1;
					line_ok[idx]    = 1'b1;
					line_tag_q[idx] = tg;
				end
			end
			KIND_INVAL: line_ok = '0;
			KIND_ZERO: begin
				hits_q   = '0;
				misses_q = '0;
			end
			default: ;
		endcase
		r.hit_count  = hits_q;
		r.miss_count = misses_q;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
		input logic [CNT_W-1:0] want);
		$display("mismatch on result %0d: %s got %0d expected %0d",
			results_seen, what, got, want);
		errors++;
	endtask

	task automatic add_row(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
		input int typed, input int h, input int hc, input int mc);
		stim_row_t row;
		row.kind           = k;
		row.addr           = a;
		row.typed          = (typed != 0);
		row.res.hit        = (h != 0);
		row.res.hit_count  = CNT_W'(hc);
		row.res.miss_count = CNT_W'(mc);
		dir_rows.push_back(row);
	endtask

	task automatic send_item(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
		input logic typed, input result_t r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		addr      <= a;
		row_typed <= typed;
		row_res   <= r;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (in_valid === 1'b1 && in_stall === 1'b1)
			n_held_off++;
		if (in_valid === 1'b1 && in_stall === 1'b0) begin
			want = lookup_and_count(kind, addr);
			if (row_typed)
				want = row_res;
			predicted_results.push_back(want);
			case (kind)
				KIND_ACCESS: n_access++;
				KIND_INVAL:  n_inval++;
				KIND_ZERO:   n_zero++;
				default:     n_unused++;
			endcase
		end
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			results_seen++;
			if (predicted_results.size() == 0) begin
				report_mismatch("unexpected result, hit_count", hit_count, '0);
			end else begin
				want = predicted_results.pop_front();
				if (hit !== want.hit)
					report_mismatch("hit", CNT_W'(hit), CNT_W'(want.hit));
				if (hit_count !== want.hit_count)
					report_mismatch("hit_count", hit_count, want.hit_count);
				if (miss_count !== want.miss_count)
					report_mismatch("miss_count", miss_count, want.miss_count);
				if (hit === 1'b1)
					n_hits++;
			end
		end
	end

	initial begin
		do begin
			@(posedge clk);
			cycle_cnt++;
		end while (cycle_cnt < CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_cnt, predicted_results.size());
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int stall_len;
		out_stall <= 1'b0;
		repeat (RESET_CYCLES + 1) @(posedge clk);
		forever begin
			if (hold_req) begin
				stall_len = HOLD_CYCLES;
				hold_req  = 1'b0;
			end else begin
				stall_len = no_idle ? 0 : $urandom_range(0, 19);
			end
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
		end
	end

	initial begin
		int                n;
		int                sel;
		logic [KIND_W-1:0] k;
		logic [ADDR_W-1:0] a;
		logic [TAG_W-1:0]  tg;
		result_t           none;
		none      = '0;
		line_ok   = '0;
		hits_q    = '0;
		misses_q  = '0;
		for (int i = 0; i < NUM_LINES; i++)
			line_tag_q[i] = '0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		kind      <= KIND_ACCESS;
		addr      <= '0;
		row_typed <= 1'b0;
		row_res   <= '0;

		add_row(KIND_ACCESS, 32'h0000_0000, 1, 0, 0, 1);
		add_row(KIND_ACCESS, 32'h0000_0000, 1, 1, 1, 1);
		add_row(KIND_ACCESS, 32'hFFFF_FFFF, 1, 0, 1, 2);
		add_row(KIND_ACCESS, 32'hFFFF_FFFF, 1, 1, 2, 2);
		add_row(KIND_ACCESS, 32'h0000_03FF, 1, 1, 3, 2);
		add_row(KIND_ACCESS, 32'h0000_8000, 1, 0, 3, 3);
		add_row(KIND_ACCESS, 32'h0000_0000, 1, 0, 3, 4);
		add_row(KIND_UNUSED, 32'hFFFF_FFFF, 1, 0, 3, 4);
		add_row(KIND_ACCESS, 32'h0000_0000, 1, 1, 4, 4);
		add_row(KIND_INVAL,  32'h0000_0000, 1, 0, 4, 4);
		add_row(KIND_ACCESS, 32'h0000_0000, 1, 0, 4, 5);
		add_row(KIND_ACCESS, 32'hFFFF_FFFF, 1, 0, 4, 6);
		add_row(KIND_ZERO,   32'h0000_0000, 1, 0, 0, 0);
		add_row(KIND_ACCESS, 32'h0000_0000, 1, 1, 1, 0);
		add_row(KIND_ACCESS, 32'hAAAA_AAAA, 0, 0, 0, 0);
		add_row(KIND_ACCESS, 32'h5555_5555, 0, 0, 0, 0);
		add_row(KIND_ACCESS, 32'hAAAA_AAAA, 0, 0, 0, 0);
		add_row(KIND_UNUSED, 32'h0000_0000, 0, 0, 0, 0);
		add_row(KIND_ZERO,   32'h1234_5678, 1, 0, 0, 0);
		add_row(KIND_INVAL,  32'hFFFF_FFFF, 1, 0, 0, 0);
		add_row(KIND_ACCESS, 32'h0000_7C00, 0, 0, 0, 0);
		add_row(KIND_ACCESS, 32'h0000_7FFF, 0, 0, 0, 0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_item(dir_rows[i].kind, dir_rows[i].addr, dir_rows[i].typed,
				dir_rows[i].res);

		n = 0;
		while (n < RAND_ITEMS) begin
			sel = $urandom_range(0, 99);
			a   = $urandom;
			if (sel < 86) begin
				k = KIND_ACCESS;
				case ($urandom_range(0, 3))
					0: tg = '0;
					1: tg = TAG_W'(1);
					2: tg = '1;
					default: tg = TAG_W'($urandom_range(2, 5));
				endcase
				a = {tg, a[OFS_W +: IDX_W], a[OFS_W-1:0]};
			end else if (sel < 89) begin
				k = KIND_INVAL;
			end else if (sel < 92) begin
				k = KIND_ZERO;
			end else if (sel < 96) begin
				k = KIND_UNUSED;
			end else begin
				k = KIND_ACCESS;
			end
			send_item(k, a, 1'b0, none);
			if (k != KIND_UNUSED) begin
				n++;
				if (n % PHASE_LEN == 0)
					no_idle = ($urandom_range(0, 3) == 0);
				if (n == HOLD_AT) begin
					hold_req = 1'b1;
					no_idle  = 1'b1;
				end
			end
		end
		in_valid <= 1'b0;

		while (predicted_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d accesses (%0d hits), %0d invalidates,",
			n_access, n_hits, n_inval);
		$display("  %0d counter clears, %0d unused kinds, %0d results in %0d cycles",
			n_zero, n_unused, results_seen, cycle_cnt);
		$display("input held off on %0d offered cycles", n_held_off);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
